### rtl/sequential_array_list_macros.svh
// Assertion macros for the sequential array list.
// Used by the top level only; no other dependencies.
`ifndef SEQUENTIAL_ARRAY_LIST_MACROS_SVH
`define SEQUENTIAL_ARRAY_LIST_MACROS_SVH

`ifndef ASSERT_OFF
`define SAL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SAL_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SAL_ASSERT(label, clk, rst_n, prop, msg)
`define SAL_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### rtl/sal_pkg.sv
// Shared types, sizes and field helpers for the sequential array list.
// No dependencies; imported by sal_seq and sequential_array_list.
package sal_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 6;
    localparam int FIDX_W    = 6;
    localparam int LEN_W     = 7;
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int IDXX_W    = (FIDX_W > ADDR_W) ? FIDX_W : ADDR_W;
    localparam int LENX_W    = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W;
    localparam int M_FIELD_W = 1 + 1 + FIDX_W + LEN_W + 1 + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_CHANGE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_DEL,
        ST_SRCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [ADDR_W-1:0] fidx;
        logic [CNT_W-1:0]  cnt;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [CMP_W-1:0] pos_ext(input logic [POS_W-1:0] p);
        return CMP_W'(p);
    endfunction

    function automatic logic [CMP_W-1:0] cnt_ext(input logic [CNT_W-1:0] c);
        return CMP_W'(c);
    endfunction

    function automatic logic [LEN_W-1:0] len_field(input logic [CNT_W-1:0] c);
        logic [LENX_W-1:0] t;
        t = LENX_W'(c);
        return t[LEN_W-1:0];
    endfunction

    function automatic logic [FIDX_W-1:0] idx_field(input logic [ADDR_W-1:0] a);
        logic [IDXX_W-1:0] t;
        t = IDXX_W'(a);
        return t[FIDX_W-1:0];
    endfunction

endpackage

### rtl/sal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sal_seq.sv
// Command sequencer: walks the element RAM for insert, delete and search, writes it for change,
// and keeps the entry count, which clear empties. Depends on sal_pkg.
module sal_seq
    import sal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [DATA_W-1:0] i_val,
    output t_ram_req          o_ram,
    input  logic [DATA_W-1:0] i_rdata,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_take
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [DATA_W-1:0]   r_val, n_val;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_wdst, n_wdst;
    logic                r_status, n_status;
    logic                r_found, n_found;
    logic [ADDR_W-1:0]   r_fidx, n_fidx;

    t_op                 w_op;
    logic [CMP_W-1:0]    w_pos_c;
    logic [CMP_W-1:0]    w_cnt_c;
    logic                w_ins_ok;
    logic                w_pos_ok;
    logic [ADDR_W-1:0]   w_idx_a;
    logic [CNT_W-1:0]    w_idx_nx;
    logic                w_del_more;
    logic                w_hit;

    assign w_op       = t_op'(i_op);
    assign w_pos_c    = pos_ext(i_pos);
    assign w_cnt_c    = cnt_ext(r_cnt);
    assign w_ins_ok   = (r_cnt < CNT_W'(CAPACITY)) && (w_pos_c <= w_cnt_c);
    assign w_pos_ok   = w_pos_c < w_cnt_c;
    assign w_idx_a    = r_idx[ADDR_W-1:0];
    assign w_idx_nx   = r_idx + CNT_W'(1);
    assign w_del_more = w_idx_nx < r_cnt;
    assign w_hit      = r_pend && (i_rdata == r_val);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (w_op)
                        OP_INSERT: n_state = w_ins_ok ? ST_INS : ST_DONE;
                        OP_DELETE: n_state = w_pos_ok ? ST_DEL : ST_DONE;
                        OP_SEARCH: n_state = ST_SRCH;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_INS: begin
                if ((w_idx_a == r_pos) && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DEL: begin
                if (!w_del_more && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_SRCH: begin
                if (w_hit || (!(r_idx < r_cnt) && !r_pend)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and RAM requests
    always_comb begin
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_val       = r_val;
        n_pend      = r_pend;
        n_wdst      = r_wdst;
        n_status    = r_status;
        n_found     = r_found;
        n_fidx      = r_fidx;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_wdst;
        o_ram.wdata = i_rdata;
        o_ram.re    = 1'b0;
        o_ram.raddr = w_idx_a;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_val    = i_val;
                    n_pos    = w_pos_c[ADDR_W-1:0];
                    n_found  = 1'b0;
                    n_fidx   = '0;
                    n_status = 1'b1;
                    n_pend   = 1'b0;
                    case (w_op)
                        OP_INSERT: begin
                            if (w_ins_ok) begin
                                n_status = 1'b0;
                                n_idx    = r_cnt;
                            end
                        end
                        OP_DELETE: begin
                            if (w_pos_ok) begin
                                n_status = 1'b0;
                                n_idx    = w_pos_c[CNT_W-1:0];
                            end
                        end
                        OP_CHANGE: begin
                            if (w_pos_ok) begin
                                n_status    = 1'b0;
                                o_ram.we    = 1'b1;
                                o_ram.waddr = w_pos_c[ADDR_W-1:0];
                                o_ram.wdata = i_val;
                            end
                        end
                        OP_SEARCH: begin
                            n_status = 1'b0;
                            n_idx    = '0;
                        end
                        OP_CLEAR: begin
                            n_status = 1'b0;
                            n_cnt    = '0;
                        end
                        default: n_status = 1'b1;
                    endcase
                end
            end
            ST_INS: begin
                // move the entry read last cycle one slot up
                o_ram.we = r_pend;
                if (w_idx_a != r_pos) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_idx_a - ADDR_W'(1);
                    n_pend      = 1'b1;
                    n_wdst      = w_idx_a;
                    n_idx       = r_idx - CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_pos;
                        o_ram.wdata = r_val;
                        n_cnt       = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_DEL: begin
                // move the entry read last cycle one slot down
                o_ram.we = r_pend;
                if (w_del_more) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_idx_nx[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_wdst      = w_idx_a;
                    n_idx       = w_idx_nx;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            ST_SRCH: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_fidx  = r_wdst;
                    n_pend  = 1'b0;
                end else if (r_idx < r_cnt) begin
                    o_ram.re = 1'b1;
                    n_pend   = 1'b1;
                    n_wdst   = w_idx_a;
                    n_idx    = w_idx_nx;
                end else begin
                    n_pend = 1'b0;
                end
            end
            ST_DONE: begin
                n_pend = 1'b0;
            end
            default: n_pend = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_wdst   <= n_wdst;
        r_status <= n_status;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = '{status: r_status, found: r_found, fidx: r_fidx, cnt: r_cnt};

endmodule

### rtl/sequential_array_list.sv
// Sequential array list: insert, delete, change, search and clear on a list in one RAM.
// Change, clear and rejected commands complete without a walk; insert moves the entries from
// the end down to the position, delete moves those above it, search reads from the start.
// One command at a time, set by the single walk over the element RAM.
// Reset (synchronous, active low) empties the list; RAM contents are not cleared.
// Depends on sal_pkg, sal_seq, sal_ram and sequential_array_list_macros.svh.
`include "sequential_array_list_macros.svh"

module sequential_array_list
    import sal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [2:0] opcode
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [0] status, [1] found, [7:2] found_index, [14:8] length, [15] empty_res,
    // [16] full_res, [23:17] zero
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    t_ram_req             w_ram;
    logic [DATA_W-1:0]    w_rdata;
    logic                 w_res_valid;
    t_result              w_res;
    logic                 w_take;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic [M_FIELD_W-1:0] w_fields;

    sal_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser[OP_W-1:0]),
        .i_pos       (i_s_tdata[POS_W-1:0]),
        .i_val       (i_s_tdata[POS_W+DATA_W-1:POS_W]),
        .o_ram       (w_ram),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_take      (w_take)
    );

    sal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // load the output register when it is free or being drained this cycle
    assign w_take = w_res_valid && (!r_m_valid || i_m_tready);

    assign w_fields = {
        (w_res.cnt == CNT_W'(CAPACITY)),
        (w_res.cnt == '0),
        len_field(w_res.cnt),
        idx_field(w_res.fidx),
        w_res.found,
        w_res.status
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_m_data <= M_TDATA_W'(w_fields);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    `SAL_ASSERT(a_cnt_max, i_clk, i_rst_n, w_res_valid |-> (w_res.cnt <= CNT_W'(CAPACITY)), "entry count above capacity")
    `SAL_ASSERT(a_one_cmd, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "second beat taken while a command is in flight")
    `SAL_ASSERT(a_res_hold, i_clk, i_rst_n, (w_res_valid && !w_take) |=> w_res_valid, "result dropped before the output register took it")
    `SAL_ASSERT_NEVER(a_found_rej, i_clk, i_rst_n, w_res_valid && w_res.found && w_res.status, "search hit flagged as rejected")

endmodule
